// ===== src/grid_min_cost_path_unit_assert.svh =====
// Assertion macros shared by the gmcp_cell_stage and top-level modules.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef GRID_MIN_COST_PATH_UNIT_ASSERT_SVH
`define GRID_MIN_COST_PATH_UNIT_ASSERT_SVH

// Check a property outside reset.
`define GMCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define GMCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/gmcp_pkg.sv =====
// Package for the grid min cost path unit: widths, payload types, register codes.
// No dependencies.
`timescale 1ns / 1ps
package gmcp_pkg;

  localparam int COST_W       = 16;
  localparam int PATH_W       = 25;
  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 2;
  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 256;

  typedef logic signed [COST_W-1:0] cost_t;
  typedef logic signed [PATH_W-1:0] path_t;
  typedef logic [CFG_W-1:0]         cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam cfg_idx_t REG_ROW_COUNT = cfg_idx_t'(0);
  localparam cfg_idx_t REG_COL_COUNT = cfg_idx_t'(1);

  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_cell;
  } cell_flags_t;

endpackage

// ===== src/gmcp_if.sv =====
// Valid/ready channel interfaces for cell costs in and path costs out.
// Depends on gmcp_pkg.
`timescale 1ns / 1ps
interface gmcp_cell_if;
  logic            valid;
  logic            ready;
  gmcp_pkg::cost_t cell_cost;
  modport source (output valid, output cell_cost, input ready);
  modport sink (input valid, input cell_cost, output ready);
endinterface

interface gmcp_result_if;
  logic            valid;
  logic            ready;
  gmcp_pkg::path_t min_path_cost;
  modport source (output valid, output min_path_cost, input ready);
  modport sink (input valid, input min_path_cost, output ready);
endinterface

// ===== src/gmcp_row_buf.sv =====
// Row buffer of best path costs, one write and one registered read per cycle.
// Depends on gmcp_pkg.
`timescale 1ns / 1ps
module gmcp_row_buf #(
  parameter int MAX_COLS = gmcp_pkg::DEF_MAX_COLS,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [CW-1:0]   rd_addr_i,
  output gmcp_pkg::path_t rd_data_o,
  input  logic            wr_en_i,
  input  logic [CW-1:0]   wr_addr_i,
  input  gmcp_pkg::path_t wr_data_i
);
  import gmcp_pkg::*;

  path_t mem [MAX_COLS];
  path_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/gmcp_cell_stage.sv =====
// Cell stage: best cost of one cell from its three neighbors, plus result register.
// Depends on gmcp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "grid_min_cost_path_unit_assert.svh"
module gmcp_cell_stage #(
  parameter int MAX_COLS = gmcp_pkg::DEF_MAX_COLS,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  logic                  accept_i,
  input  gmcp_pkg::cost_t       cost_i,
  input  gmcp_pkg::cell_flags_t flags_i,
  input  logic [CW-1:0]         col_i,
  input  gmcp_pkg::path_t       above_rd_i,
  output logic                  in_ready_o,
  output logic                  wr_en_o,
  output logic [CW-1:0]         wr_col_o,
  output gmcp_pkg::path_t       wr_data_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output gmcp_pkg::path_t       out_cost_o
);
  import gmcp_pkg::*;

  logic          s1_valid_q;
  cost_t         cost_q;
  cell_flags_t   flags_q;
  logic [CW-1:0] col_q;
  logic          fwd_q;
  path_t         left_q;
  path_t         diag_q;
  logic          out_valid_q;
  path_t         out_q;

  path_t above;
  path_t cost_ext;
  path_t min_al;
  path_t min3;
  path_t best;
  logic  retire;

  assign above    = fwd_q ? left_q : above_rd_i;
  assign cost_ext = {{(PATH_W-COST_W){cost_q[COST_W-1]}}, cost_q};

  always_comb begin
    min_al = (above < left_q) ? above : left_q;
    min3   = (min_al < diag_q) ? min_al : diag_q;
    if (flags_q.first_row && flags_q.first_col) begin
      best = cost_ext;
    end else if (flags_q.first_row) begin
      best = left_q + cost_ext;
    end else if (flags_q.first_col) begin
      best = above + cost_ext;
    end else begin
      best = min3 + cost_ext;
    end
  end

  assign retire     = s1_valid_q && (!flags_q.last_cell || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || retire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      left_q      <= '0;
      diag_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_valid_q && (col_q == col_i);
      end else if (retire) begin
        s1_valid_q <= 1'b0;
        fwd_q      <= 1'b0;
      end
      if (restart_i) begin
        left_q <= '0;
        diag_q <= '0;
      end else if (retire) begin
        left_q <= best;
        diag_q <= above;
      end
      if (retire && flags_q.last_cell) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cost_q  <= cost_i;
      flags_q <= flags_i;
      col_q   <= col_i;
    end
    if (retire && flags_q.last_cell) begin
      out_q <= best;
    end
  end

  assign wr_en_o     = retire;
  assign wr_col_o    = col_q;
  assign wr_data_o   = best;
  assign out_valid_o = out_valid_q;
  assign out_cost_o  = out_q;

  `GMCP_ASSERT(a_stall_holds, s1_valid_q && !retire |=> s1_valid_q && $stable(cost_q) && $stable(col_q), "stalled cell changed")
  `GMCP_ASSERT(a_last_to_out, retire && flags_q.last_cell |=> out_valid_q && out_q == $past(best), "last cell result lost")
  `GMCP_ASSERT(a_fwd_needs_cell, fwd_q |-> s1_valid_q, "forward flag without cell")
  `GMCP_ASSERT_ALWAYS(a_rst_no_out, !rst_ni |=> !out_valid_q && !s1_valid_q, "valid during reset")

endmodule

// ===== src/grid_min_cost_path_unit.sv =====
// Top level of the grid min cost path unit: config registers, grid position, row buffer.
// Depends on gmcp_pkg, gmcp_if, gmcp_row_buf, gmcp_cell_stage and the assertion header.
//
// Usage:
//   cell_i carries one signed 16-bit cell cost per transaction, row-major over a
//   row_count by col_count grid. Moves go right, down or diagonally down-right.
//   result_o carries one 25-bit least path cost per grid, after its last cell.
//   cfg_we_i / cfg_idx_i / cfg_wdata_i write row_count (index 0) or col_count
//   (index 1) while the unit is idle; a write restarts the grid. A count of zero
//   acts as one, a count above the maximum acts as the maximum.
// Throughput: one cell per cycle, set by the combinational add and three-way
//   minimum and by the one-read, one-write row buffer, unless a last cell stalls.
// Result: a last cell is registered in the cell stage, then its path cost in
//   the result register once that register is free.
// Reset: both counts become one and the grid position returns to the first
//   cell. The row buffer is not cleared; the first row of every grid fills it.
// Stall: the result register holds its value while result_o.ready is low.
//   Cells other than a grid's last keep flowing; a last cell waits in the cell
//   stage and cell_i.ready drops until the result register frees.
`timescale 1ns / 1ps
`include "grid_min_cost_path_unit_assert.svh"
module grid_min_cost_path_unit #(
  parameter int MAX_COLS = gmcp_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gmcp_pkg::DEF_MAX_ROWS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  gmcp_pkg::cfg_idx_t  cfg_idx_i,
  input  gmcp_pkg::cfg_data_t cfg_wdata_i,
  gmcp_cell_if.sink           cell_i,
  gmcp_result_if.source       result_o
);
  import gmcp_pkg::*;

  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);

  cfg_data_t     row_count_q;
  cfg_data_t     col_count_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;

  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cols_eff;
  logic           idx_ok;
  logic [RW-1:0]  row_cur;
  logic [CW-1:0]  col_cur;
  logic           last_row;
  logic           last_col;
  logic           cfg_hit;
  logic           accept;
  cell_flags_t    flags;

  logic          rd_unused_en;
  path_t         above_rd;
  logic          wr_en;
  logic [CW-1:0] wr_col;
  path_t         wr_data;

  always_comb begin
    if (row_count_q == '0) begin
      rows_eff = RCW'(1);
    end else if (32'(row_count_q) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(row_count_q);
    end
    if (col_count_q == '0) begin
      cols_eff = CCW'(1);
    end else if (32'(col_count_q) > MAX_COLS) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(col_count_q);
    end
  end

  assign idx_ok   = (RCW'(row_q) < rows_eff) && (CCW'(col_q) < cols_eff);
  assign row_cur  = idx_ok ? row_q : '0;
  assign col_cur  = idx_ok ? col_q : '0;
  assign last_row = (RCW'(row_cur) + RCW'(1)) == rows_eff;
  assign last_col = (CCW'(col_cur) + CCW'(1)) == cols_eff;

  assign flags.first_row = (row_cur == '0);
  assign flags.first_col = (col_cur == '0);
  assign flags.last_cell = last_row && last_col;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_ROW_COUNT || cfg_idx_i == REG_COL_COUNT);
  assign accept  = cell_i.valid && cell_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= cfg_data_t'(1);
      col_count_q <= cfg_data_t'(1);
      row_q       <= '0;
      col_q       <= '0;
    end else if (cfg_hit) begin
      case (cfg_idx_i)
        REG_ROW_COUNT: row_count_q <= cfg_wdata_i;
        REG_COL_COUNT: col_count_q <= cfg_wdata_i;
        default: ;
      endcase
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : RW'(row_cur + RW'(1));
      end else begin
        col_q <= CW'(col_cur + CW'(1));
        row_q <= row_cur;
      end
    end
  end

  assign rd_unused_en = accept;

  gmcp_row_buf #(
    .MAX_COLS (MAX_COLS)
  ) u_row_buf (
    .clk_i     (clk_i),
    .rd_en_i   (rd_unused_en),
    .rd_addr_i (col_cur),
    .rd_data_o (above_rd),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_col),
    .wr_data_i (wr_data)
  );

  gmcp_cell_stage #(
    .MAX_COLS (MAX_COLS)
  ) u_cell_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_hit),
    .accept_i    (accept),
    .cost_i      (cell_i.cell_cost),
    .flags_i     (flags),
    .col_i       (col_cur),
    .above_rd_i  (above_rd),
    .in_ready_o  (cell_i.ready),
    .wr_en_o     (wr_en),
    .wr_col_o    (wr_col),
    .wr_data_o   (wr_data),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_cost_o  (result_o.min_path_cost)
  );

  `GMCP_ASSERT(a_cfg_restart, cfg_hit |=> row_q == '0 && col_q == '0, "config write did not restart grid")
  `GMCP_ASSERT(a_grid_wrap, accept && !cfg_hit && flags.last_cell |=> row_q == '0 && col_q == '0, "grid did not wrap")
  `GMCP_ASSERT(a_index_in_range, idx_ok, "grid position outside counts")

endmodule
